// ===== design/ttc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants of the tick time counter: operation codes,
// register indexes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ttc_pkg;

    localparam int FREQ_BITS      = 32;
    localparam int SEC_BITS       = 32;
    localparam int US_BITS        = 20;
    localparam int AMT_BITS       = 16;
    localparam int OP_BITS        = 3;
    localparam int PER_US_BITS    = 13;
    localparam int PER_MS_BITS    = 23;
    localparam int DELAY_N_BITS   = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam int S_TDATA_BITS   = 72;
    localparam int M_TDATA_BITS   = 56;
    // Quotient bits produced when a 32-bit value is divided.
    localparam int FRAC_STEPS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_FREQUENCY = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_ENABLE   = 1'b1;

    localparam logic [FREQ_BITS-1:0]    MICROS_PER_SEC = 32'd1000000;
    localparam logic [FREQ_BITS-1:0]    MILLIS_PER_SEC = 32'd1000;
    localparam logic [AMT_BITS-1:0]     DELAY_LIMIT    = 16'd5000;
    localparam logic [US_BITS-1:0]      US_MAX         = 20'd999999;
    localparam logic [SEC_BITS-1:0]     SEC_MAX        = 32'hFFFF_FFFF;
    localparam logic [FREQ_BITS-1:0]    FREQ_RESET     = 32'd18000000;
    localparam logic [PER_US_BITS-1:0]  PER_US_RESET   =
        PER_US_BITS'(FREQ_RESET / MICROS_PER_SEC);
    localparam logic [PER_MS_BITS-1:0]  PER_MS_RESET   =
        PER_MS_BITS'(FREQ_RESET / MILLIS_PER_SEC);

    // Reciprocals of one million and one thousand, scaled by 2^50 and 2^38
    // and rounded up. The product with any 32-bit frequency, shifted right by
    // the scale, is the exact quotient.
    localparam int               PER_US_SHIFT = 50;
    localparam int               PER_MS_SHIFT = 38;
    localparam logic [FREQ_BITS-1:0] PER_US_RECIP = 32'd1125899907;
    localparam logic [FREQ_BITS-1:0] PER_MS_RECIP = 32'd274877907;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK  = 3'd0,
        OP_SET   = 3'd1,
        OP_GET   = 3'd2,
        OP_START = 3'd3,
        OP_POLL  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MUL_SEC_FREQ,
        MUL_US_PER_US,
        MUL_DELAY,
        MUL_PER_US,
        MUL_PER_MS
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_SEC,
        DIV_US
    } div_mode_t;

    typedef struct packed {
        logic      load_item;
        logic      count_tick;
        logic      count_load;
        logic      mul_en;
        mul_sel_t  mul_sel;
        logic      acc_load;
        logic      delay_latch;
        logic      poll_eval;
        logic      div_start;
        div_mode_t div_mode;
        logic      cap_seconds;
        logic      cap_micros;
        logic      cap_per_us;
        logic      cap_per_ms;
        logic      emit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic freq_zero;
        logic per_us_zero;
    } dp_stat_t;

endpackage

// ===== design/ttc_div.sv =====
// ----------------------------------------------------------------------------
// ttc_div
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left aligned; after the requested number of steps the quotient sits in
// the low bits of quo and the remainder in rem.
// ----------------------------------------------------------------------------
module ttc_div #(
    parameter int COUNT_BITS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [COUNT_BITS-1:0]             dividend,
    input  logic [31:0]                       divisor,
    input  logic [$clog2(COUNT_BITS+1)-1:0]   steps,
    output logic [COUNT_BITS-1:0]             quo,
    output logic [31:0]                       rem,
    output logic                              done
);

    localparam int STEP_BITS = $clog2(COUNT_BITS + 1);

    logic [COUNT_BITS-1:0] quo_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           divisor_reg;
    logic [STEP_BITS-1:0]  steps_reg;
    logic [32:0]           shifted;
    logic [32:0]           diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[COUNT_BITS-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (start) begin
            steps_reg <= steps;
        end else if (steps_reg != '0) begin
            steps_reg <= steps_reg - 1'b1;
        end
    end

    // The remainder stays below the divisor, so its top bit is never needed.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (steps_reg != '0) begin
            quo_reg <= {quo_reg[COUNT_BITS-2:0], fits};
            rem_reg <= fits ? diff[31:0] : shifted[31:0];
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = (steps_reg == '0);

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> done)
        else $error("divider started while busy");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done)
        else $error("divider did not become busy after start");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (!done && !start) |=> (steps_reg == $past(steps_reg) - 1'b1))
        else $error("divider step count skipped");
`endif

endmodule

// ===== design/ttc_dp.sv =====
// ----------------------------------------------------------------------------
// ttc_dp
// Datapath of the tick time counter: configuration registers, the counter,
// delay origin and target, a shared multiplier, the divider and the result
// register.
// ----------------------------------------------------------------------------
module ttc_dp
    import ttc_pkg::*;
#(
    parameter int COUNT_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FREQ_BITS-1:0]      cfg_wdata,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    output logic [M_TDATA_BITS-1:0]   m_tdata
);

    localparam int STEP_BITS = $clog2(COUNT_BITS + 1);

    logic [FREQ_BITS-1:0]    freq_reg;
    logic                    enable_reg;
    logic [PER_US_BITS-1:0]  per_us_reg;
    logic [PER_MS_BITS-1:0]  per_ms_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   origin_reg;
    logic [31:0]             target_reg;

    logic [SEC_BITS-1:0]     sec_in_reg;
    logic [US_BITS-1:0]      us_in_reg;
    logic [AMT_BITS-1:0]     amt_reg;
    logic                    ms_reg;
    logic [63:0]             mul_reg;
    logic [63:0]             acc_reg;
    logic [SEC_BITS-1:0]     sec_res_reg;
    logic [US_BITS-1:0]      us_res_reg;
    logic                    done_res_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;

    logic [DELAY_N_BITS-1:0] delay_n;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_prod;
    logic [63:0]             set_sum;
    logic [COUNT_BITS-1:0]   elapsed;
    logic                    reached;

    logic [COUNT_BITS-1:0]   div_dividend;
    logic [31:0]             div_divisor;
    logic [STEP_BITS-1:0]    div_steps;
    logic [COUNT_BITS-1:0]   div_quo;
    logic [31:0]             div_rem;
    logic                    div_done;

    ttc_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .quo      (div_quo),
        .rem      (div_rem),
        .done     (div_done)
    );

    assign delay_n = (amt_reg > DELAY_LIMIT) ? DELAY_LIMIT[DELAY_N_BITS-1:0]
                                             : amt_reg[DELAY_N_BITS-1:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_SEC_FREQ: begin
                mul_a = sec_in_reg;
                mul_b = freq_reg;
            end
            MUL_US_PER_US: begin
                mul_a = 32'(us_in_reg);
                mul_b = 32'(per_us_reg);
            end
            MUL_DELAY: begin
                mul_a = 32'(delay_n);
                mul_b = ms_reg ? 32'(per_ms_reg) : 32'(per_us_reg);
            end
            MUL_PER_US: begin
                mul_a = freq_reg;
                mul_b = PER_US_RECIP;
            end
            MUL_PER_MS: begin
                mul_a = freq_reg;
                mul_b = PER_MS_RECIP;
            end
            default: ;
        endcase
    end

    assign mul_prod = 64'(mul_a) * 64'(mul_b);
    assign set_sum  = acc_reg + mul_reg;
    assign elapsed  = count_reg - origin_reg;
    assign reached  = elapsed >= COUNT_BITS'(target_reg);

    // 32-bit dividends are placed in the top bits so that 32 steps suffice.
    always_comb begin
        div_dividend = count_reg;
        div_divisor  = freq_reg;
        div_steps    = STEP_BITS'(COUNT_BITS);
        case (cmd.div_mode)
            DIV_SEC: begin
                div_dividend = count_reg;
                div_divisor  = freq_reg;
                div_steps    = STEP_BITS'(COUNT_BITS);
            end
            DIV_US: begin
                div_dividend = COUNT_BITS'(div_rem) << (COUNT_BITS - 32);
                div_divisor  = 32'(per_us_reg);
                div_steps    = STEP_BITS'(FRAC_STEPS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg   <= FREQ_RESET;
            enable_reg <= 1'b0;
            per_us_reg <= PER_US_RESET;
            per_ms_reg <= PER_MS_RESET;
            count_reg  <= '0;
            origin_reg <= '0;
            target_reg <= '0;
        end else begin
            if (cfg_we && cfg_index == REG_TICK_FREQUENCY) begin
                freq_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == REG_COUNT_ENABLE) begin
                enable_reg <= cfg_wdata[0];
            end
            if (cmd.cap_per_us) begin
                per_us_reg <= mul_prod[PER_US_SHIFT +: PER_US_BITS];
            end
            if (cmd.cap_per_ms) begin
                per_ms_reg <= mul_prod[PER_MS_SHIFT +: PER_MS_BITS];
            end
            if (cmd.count_tick && enable_reg) begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end else if (cmd.count_load) begin
                count_reg <= set_sum[COUNT_BITS-1:0];
            end
            if (cmd.delay_latch) begin
                target_reg <= mul_reg[31:0];
                origin_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            sec_in_reg   <= s_tdata[31:0];
            us_in_reg    <= s_tdata[51:32];
            amt_reg      <= s_tdata[67:52];
            ms_reg       <= s_tdata[68];
            sec_res_reg  <= '0;
            us_res_reg   <= '0;
            done_res_reg <= 1'b0;
        end else begin
            if (cmd.cap_seconds) begin
                if (freq_reg == '0 || div_quo > COUNT_BITS'(SEC_MAX)) begin
                    sec_res_reg <= SEC_MAX;
                end else begin
                    sec_res_reg <= div_quo[SEC_BITS-1:0];
                end
            end
            if (cmd.cap_micros) begin
                us_res_reg <= (div_quo[31:0] > 32'(US_MAX)) ? US_MAX
                                                            : div_quo[US_BITS-1:0];
            end
            if (cmd.poll_eval) begin
                done_res_reg <= reached;
            end
        end
        if (cmd.mul_en) begin
            mul_reg <= mul_prod;
        end
        if (cmd.acc_load) begin
            acc_reg <= mul_reg;
        end
        if (cmd.emit) begin
            out_data_reg <= {3'b000, done_res_reg, us_res_reg, sec_res_reg};
        end
    end

    assign stat.div_done    = div_done;
    assign stat.freq_zero   = (freq_reg == '0);
    assign stat.per_us_zero = (per_us_reg == '0);
    assign m_tdata          = out_data_reg;

endmodule

// ===== design/ttc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttc_ctrl
// Controller of the tick time counter: sequences each operation through the
// datapath, owns the input and output handshakes and recomputes the per-unit
// tick counts after a frequency write.
// ----------------------------------------------------------------------------
module ttc_ctrl
    import ttc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [OP_BITS-1:0] in_op,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               freq_write,
    input  dp_stat_t           stat,
    output dp_cmd_t            cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECALC_MS,
        ST_TICK,
        ST_POLL,
        ST_SET_A,
        ST_SET_B,
        ST_SET_C,
        ST_START_A,
        ST_START_B,
        ST_GET,
        ST_GET_SEC,
        ST_GET_US,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   pend_reg, pend_next;
    logic   accept;
    logic   emit_fire;

    assign s_tready  = (state_reg == ST_IDLE) && !pend_reg && !freq_write;
    assign accept    = s_tvalid && s_tready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb begin
        cmd            = '0;
        cmd.mul_sel    = MUL_SEC_FREQ;
        cmd.div_mode   = DIV_SEC;
        state_next     = state_reg;
        pend_next      = pend_reg || freq_write;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    unique case (in_op)
                        OP_TICK:  state_next = ST_TICK;
                        OP_SET:   state_next = ST_SET_A;
                        OP_GET:   state_next = ST_GET;
                        OP_START: state_next = ST_START_A;
                        OP_POLL:  state_next = ST_POLL;
                        default:  state_next = ST_EMIT;
                    endcase
                end else if (pend_reg && !freq_write) begin
                    // Ticks per unit come from a reciprocal multiplication.
                    cmd.cap_per_us = 1'b1;
                    cmd.mul_sel    = MUL_PER_US;
                    pend_next      = 1'b0;
                    state_next     = ST_RECALC_MS;
                end
            end
            ST_RECALC_MS: begin
                cmd.cap_per_ms = 1'b1;
                cmd.mul_sel    = MUL_PER_MS;
                state_next     = ST_IDLE;
            end
            ST_TICK: begin
                cmd.count_tick = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_POLL: begin
                cmd.poll_eval = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_SET_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SEC_FREQ;
                state_next  = ST_SET_B;
            end
            ST_SET_B: begin
                cmd.acc_load = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_US_PER_US;
                state_next   = ST_SET_C;
            end
            ST_SET_C: begin
                cmd.count_load = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_START_A: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DELAY;
                state_next  = ST_START_B;
            end
            ST_START_B: begin
                cmd.delay_latch = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_GET: begin
                // With no frequency the seconds saturate and no division runs.
                if (stat.freq_zero) begin
                    cmd.cap_seconds = 1'b1;
                    state_next      = ST_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_mode  = DIV_SEC;
                    state_next    = ST_GET_SEC;
                end
            end
            ST_GET_SEC: begin
                if (stat.div_done) begin
                    cmd.cap_seconds = 1'b1;
                    if (stat.per_us_zero) begin
                        state_next = ST_EMIT;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_mode  = DIV_US;
                        state_next    = ST_GET_US;
                    end
                end
            end
            ST_GET_US: begin
                if (stat.div_done) begin
                    cmd.cap_micros = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in flight");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_EMIT))
        else $error("result shown without finishing an operation");

    a_freq_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        freq_write |=> !s_tready)
        else $error("input accepted before per-unit ticks were refreshed");
`endif

endmodule

// ===== design/tick_time_counter_sec_us.sv =====
// ----------------------------------------------------------------------------
// tick_time_counter_sec_us
// Tick counter with seconds/microseconds conversion and delay polling.
//
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tuser op, s_tdata operands
// m_       out  m_tvalid / m_tready  m_tdata seconds, microseconds, done
// cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// One item is in work at a time. Tick and poll update the counter or the
// done flag; set time multiplies seconds and microseconds and loads the
// counter; start delay multiplies and latches the target; unknown ops go
// straight to the result. Get time runs the restoring divider, which yields
// one quotient bit per cycle (COUNT_BITS bits of seconds, then 32 bits of
// microseconds). A frequency write recomputes ticks per microsecond and per
// millisecond by reciprocal multiplication; s_tready stays low from the
// write until both are recomputed. Reset is synchronous; there is no
// clearing pass. A result waits in the output register while the next item
// is taken; that item's result is held back until the waiting one transfers.
// ----------------------------------------------------------------------------
module tick_time_counter_sec_us
    import ttc_pkg::*;
#(
    parameter int COUNT_BITS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FREQ_BITS-1:0]      cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [31:0] set_seconds, [51:32] set_microseconds, [67:52] delay_amount,
    // [68] delay_in_ms, [71:69] zero
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    // [2:0] op
    input  logic [OP_BITS-1:0]        s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] seconds, [51:32] microseconds, [52] delay_done, [55:53] zero
    output logic [M_TDATA_BITS-1:0]   m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     freq_write;

    assign freq_write = cfg_we && (cfg_index == REG_TICK_FREQUENCY);

    ttc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_op      (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .freq_write (freq_write),
        .stat       (stat),
        .cmd        (cmd)
    );

    ttc_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

endmodule
